### rtl/sensor_frame_crc_decoder_core_assert.svh
// Assertion macros shared by the sensor frame decoder RTL.
// No dependencies; clock and reset are passed in by each use.
`ifndef SENSOR_FRAME_CRC_DECODER_CORE_ASSERT_SVH
`define SENSOR_FRAME_CRC_DECODER_CORE_ASSERT_SVH
`ifndef SYNTH
// Check a property on every rising edge outside reset.
`define SCFD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("scfd assertion failed");
// Check that a condition implies a consequence in the next cycle.
`define SCFD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("scfd assertion failed");
`else
`define SCFD_ASSERT(lbl, clk, rstn, prop)
`define SCFD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### rtl/scfd_pkg.sv
// Package for the sensor frame decoder: constants, result type, CRC and
// sign conversion functions. No dependencies.
package scfd_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Frame mode codes; the unused code behaves as MODE_BOTH
    localparam logic [1:0] MODE_TEMP_ONLY = 2'd0;
    localparam logic [1:0] MODE_HUM_ONLY  = 2'd1;
    localparam logic [1:0] MODE_BOTH      = 2'd2;

    // Payload lengths in bytes
    localparam logic [2:0] PLEN_SHORT = 3'd4;
    localparam logic [2:0] PLEN_LONG  = 3'd6;

    // Byte positions of the measurement words
    localparam logic [2:0] POS_W1_HI = 3'd2;
    localparam logic [2:0] POS_W1_LO = 3'd3;
    localparam logic [2:0] POS_W2_HI = 3'd4;
    localparam logic [2:0] POS_W2_LO = 3'd5;

    typedef struct packed {
        logic               valid;
        logic               crc_ok;
        logic signed [15:0] temperature_tenths;
        logic        [15:0] humidity_tenths;
        logic               temperature_present;
        logic               humidity_present;
    } scfd_result_t;

    // CRC-16/MODBUS update over one byte, LSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // Sign-magnitude to two's complement; negative zero gives zero
    function automatic logic [15:0] sm_to_tc(input logic [15:0] w);
        logic [15:0] mag;
        mag = {1'b0, w[14:0]};
        return w[15] ? (16'd0 - mag) : mag;
    endfunction

endpackage

### rtl/scfd_frame.sv
// Frame tracker: byte position, running CRC, measurement words, result build.
// Depends on scfd_pkg and the assertion header.
`include "sensor_frame_crc_decoder_core_assert.svh"

module scfd_frame (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  logic [7:0]            data_byte,
    input  logic                  first_of_frame,
    input  logic [1:0]            read_mode,
    output scfd_pkg::scfd_result_t result
);
    import scfd_pkg::*;

    logic [15:0] crc_reg, crc_next;
    logic [2:0]  pos_reg, pos_next;
    logic [15:0] word1_reg, word1_next;
    logic [15:0] word2_reg, word2_next;
    logic [7:0]  crc_lo_reg, crc_lo_next;

    logic [15:0] crc_cur;
    logic [2:0]  pos;
    logic [2:0]  plen;
    logic        temp_present;
    logic        hum_present;
    logic        temp_from_word2;

    // Restart position and CRC ahead of a frame-start byte
    assign pos     = first_of_frame ? 3'd0 : pos_reg;
    assign crc_cur = first_of_frame ? CRC_INIT : crc_reg;

    // Decode frame layout from the mode
    always_comb begin
        case (read_mode)
            MODE_TEMP_ONLY: begin
                plen            = PLEN_SHORT;
                temp_present    = 1'b1;
                hum_present     = 1'b0;
                temp_from_word2 = 1'b0;
            end
            MODE_HUM_ONLY: begin
                plen            = PLEN_SHORT;
                temp_present    = 1'b0;
                hum_present     = 1'b1;
                temp_from_word2 = 1'b0;
            end
            default: begin
                plen            = PLEN_LONG;
                temp_present    = 1'b1;
                hum_present     = 1'b1;
                temp_from_word2 = 1'b1;
            end
        endcase
    end

    // Advance frame state and build the result word
    always_comb begin
        crc_next    = crc_reg;
        pos_next    = pos_reg;
        word1_next  = word1_reg;
        word2_next  = word2_reg;
        crc_lo_next = crc_lo_reg;

        result.valid               = 1'b0;
        result.crc_ok              = ({data_byte, crc_lo_reg} == crc_cur);
        result.temperature_tenths  = temp_present
            ? sm_to_tc(temp_from_word2 ? word2_reg : word1_reg) : 16'd0;
        result.humidity_tenths     = hum_present ? word1_reg : 16'd0;
        result.temperature_present = temp_present;
        result.humidity_present    = hum_present;

        if (pos < plen) begin
            crc_next = crc16_byte(crc_cur, data_byte);
            pos_next = pos + 3'd1;
            case (pos)
                POS_W1_HI: word1_next[15:8] = data_byte;
                POS_W1_LO: word1_next[7:0]  = data_byte;
                POS_W2_HI: word2_next[15:8] = data_byte;
                POS_W2_LO: word2_next[7:0]  = data_byte;
                default:   word1_next       = word1_reg;
            endcase
        end else if (pos == plen) begin
            crc_next    = crc_cur;
            crc_lo_next = data_byte;
            pos_next    = pos + 3'd1;
        end else begin
            crc_next     = CRC_INIT;
            pos_next     = 3'd0;
            result.valid = 1'b1;
        end
    end

    // Update state only on an accepted byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg    <= CRC_INIT;
            pos_reg    <= 3'd0;
            word1_reg  <= 16'd0;
            word2_reg  <= 16'd0;
            crc_lo_reg <= 8'd0;
        end else if (accept) begin
            crc_reg    <= crc_next;
            pos_reg    <= pos_next;
            word1_reg  <= word1_next;
            word2_reg  <= word2_next;
            crc_lo_reg <= crc_lo_next;
        end
    end

    `SCFD_ASSERT_NEXT(a_final_restarts, aclk, aresetn, accept && result.valid,
        pos_reg == 3'd0 && crc_reg == CRC_INIT)
    `SCFD_ASSERT_NEXT(a_start_advances, aclk, aresetn, accept && first_of_frame,
        pos_reg == 3'd1)
    `SCFD_ASSERT_NEXT(a_idle_holds, aclk, aresetn, !accept,
        $stable(crc_reg) && $stable(pos_reg))

endmodule

### rtl/scfd_out.sv
// Result register: holds one decoded frame result until taken downstream.
// Depends on scfd_pkg and the assertion header.
`include "sensor_frame_crc_decoder_core_assert.svh"

module scfd_out (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load,
    input  scfd_pkg::scfd_result_t result_in,
    input  logic                  m_ready,
    output logic                  m_valid,
    output scfd_pkg::scfd_result_t result_out
);
    import scfd_pkg::*;

    logic         valid_reg, valid_next;
    scfd_result_t data_reg;

    // Set on load, drop once taken
    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Capture payload on load
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result_in;
        end
    end

    assign m_valid    = valid_reg;
    assign result_out = data_reg;

    `SCFD_ASSERT_NEXT(a_load_sets, aclk, aresetn, load, valid_reg)
    `SCFD_ASSERT_NEXT(a_stall_keeps, aclk, aresetn, valid_reg && !m_ready && !load,
        valid_reg && $stable(data_reg))
    `SCFD_ASSERT_NEXT(a_empty_stays, aclk, aresetn, !valid_reg && !load, !valid_reg)

endmodule

### rtl/sensor_frame_crc_decoder_core.sv
// Top level of the sensor frame decoder: ports, mode register, wiring.
// Depends on scfd_pkg, scfd_frame and scfd_out.
//
// channel  direction  handshake              payload
// s_       in         s_valid / s_ready      s_data_byte, s_first_of_frame
// m_       out        m_valid / m_ready      m_crc_ok, m_*_tenths, m_*_present
// cfg_     in         cfg_valid / cfg_ready  cfg_read_mode
//
// One byte is taken per cycle while s_ready is high; the CRC update, position
// decode and result build sit between the frame state and the result register.
// A frame's result appears on m_ in the cycle after its final byte is taken.
// s_ready drops only while a result waits and m_ready is low.
// Synchronous active-low reset clears position, CRC, result valid; mode to 2.
module sensor_frame_crc_decoder_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_data_byte,
    input  logic               s_first_of_frame,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_crc_ok,
    output logic signed [15:0] m_temperature_tenths,
    output logic        [15:0] m_humidity_tenths,
    output logic               m_temperature_present,
    output logic               m_humidity_present,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_read_mode
);
    import scfd_pkg::*;

    logic         [1:0] read_mode_reg;
    logic               in_accept;
    scfd_result_t       frame_result;
    scfd_result_t       out_result;

    // Mode register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            read_mode_reg <= MODE_BOTH;
        end else if (cfg_valid) begin
            read_mode_reg <= cfg_read_mode;
        end
    end

    // Accept while the result register is free or draining
    assign s_ready   = !m_valid || m_ready;
    assign in_accept = s_valid && s_ready;

    scfd_frame u_frame (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (in_accept),
        .data_byte      (s_data_byte),
        .first_of_frame (s_first_of_frame),
        .read_mode      (read_mode_reg),
        .result         (frame_result)
    );

    scfd_out u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (in_accept && frame_result.valid),
        .result_in  (frame_result),
        .m_ready    (m_ready),
        .m_valid    (m_valid),
        .result_out (out_result)
    );

    // Unpack result word onto ports
    assign m_crc_ok              = out_result.crc_ok;
    assign m_temperature_tenths  = out_result.temperature_tenths;
    assign m_humidity_tenths     = out_result.humidity_tenths;
    assign m_temperature_present = out_result.temperature_present;
    assign m_humidity_present    = out_result.humidity_present;

endmodule
